// ----- hdl/periodic_task_timer_table_defines.svh -----
// ----------------------------------------------------------------------------
// periodic task timer table assertion macros
// shared property shapes for the port checker
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_TIMER_TABLE_DEFINES_SVH
`define PERIODIC_TASK_TIMER_TABLE_DEFINES_SVH

// same-cycle implication, inactive while in reset
`define PTT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, inactive while in reset
`define PTT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/ptt_pkg.sv -----
// ----------------------------------------------------------------------------
// ptt_pkg
// types, codes and constants of the periodic task timer table
// ----------------------------------------------------------------------------
package ptt_pkg;

	localparam int NUM_SLOTS_DEF = 8;
	localparam int MAX_RESULTS   = 8;
	localparam int SLOT_W        = 3;
	localparam int CMD_W         = 3;
	localparam int RUNS_W        = 16;
	localparam int PERIOD_W      = 15;
	localparam int CD_W          = 16;
	localparam int CMP_W         = 7;

	localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD = 15'd30000;
	localparam logic [CD_W-1:0]     CD_SPENT       = 16'hFFFF;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_TICK     = 3'd0,
		CMD_DISPATCH = 3'd1,
		CMD_START    = 3'd2,
		CMD_STOP     = 3'd3,
		CMD_RESUME   = 3'd4,
		CMD_SET_PER  = 3'd5
	} cmd_t;

	// one timer slot
	typedef struct packed {
		logic                     enabled;
		logic signed [RUNS_W-1:0] runs_left;
		logic [PERIOD_W-1:0]      period;
		logic signed [CD_W-1:0]   countdown;
		logic                     has_action;
	} slot_entry_t;

	// update unit result
	typedef struct packed {
		slot_entry_t nxt;
		logic        we;
		logic        serviced;
		logic        fired;
	} slot_upd_t;

endpackage

// ----- hdl/ptt_slot_mem.sv -----
// ----------------------------------------------------------------------------
// ptt_slot_mem
// slot table storage, one read and one write port, registered read,
// per-entry valid bits so a never-written slot reads as cleared
// ----------------------------------------------------------------------------
module ptt_slot_mem #(
	parameter int DEPTH = ptt_pkg::NUM_SLOTS_DEF,
	parameter int IDX_W = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [IDX_W-1:0]     rd_addr,
	output ptt_pkg::slot_entry_t rd_data,
	input  logic                 wr_en,
	input  logic [IDX_W-1:0]     wr_addr,
	input  ptt_pkg::slot_entry_t wr_data
);

	ptt_pkg::slot_entry_t mem [DEPTH];
	logic [DEPTH-1:0]     valid_q;
	ptt_pkg::slot_entry_t data_q;
	logic                 data_vld_q;

	// storage write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_vld_q <= 1'b0;
		end else if (rd_en) begin
			data_vld_q <= valid_q[rd_addr];
		end
	end

	assign rd_data = data_vld_q ? data_q : '0;

endmodule

// ----- hdl/ptt_slot_alu.sv -----
// ----------------------------------------------------------------------------
// ptt_slot_alu
// shared slot update unit: applies one command to one slot entry
// ----------------------------------------------------------------------------
module ptt_slot_alu (
	input  ptt_pkg::cmd_t                       cmd,
	input  ptt_pkg::slot_entry_t                cur,
	input  logic signed [ptt_pkg::RUNS_W-1:0]   run_count,
	input  logic [ptt_pkg::PERIOD_W-1:0]        period,
	input  logic                                has_action,
	output ptt_pkg::slot_upd_t                  upd
);

	logic cd_pos;
	logic runs_pos;
	logic due;

	assign cd_pos   = !cur.countdown[ptt_pkg::CD_W-1] && (cur.countdown != '0);
	assign runs_pos = !cur.runs_left[ptt_pkg::RUNS_W-1] && (cur.runs_left != '0);
	assign due      = cur.enabled && (cur.countdown == '0);

	always_comb begin
		upd.nxt      = cur;
		upd.we       = 1'b0;
		upd.serviced = 1'b0;
		upd.fired    = 1'b0;
		case (cmd)
			// count down every slot whose countdown is positive, enabled or not
			ptt_pkg::CMD_TICK: begin
				if (cd_pos) begin
					upd.nxt.countdown = cur.countdown - ptt_pkg::CD_W'(1);
					upd.we            = 1'b1;
				end
			end
			// service a due slot
			ptt_pkg::CMD_DISPATCH: begin
				if (due) begin
					upd.we            = 1'b1;
					upd.serviced      = 1'b1;
					upd.nxt.countdown = ptt_pkg::CD_SPENT;
					if (cur.runs_left != '0) begin
						upd.nxt.countdown = {1'b0, cur.period};
						upd.fired         = cur.has_action;
					end
					if (runs_pos) begin
						upd.nxt.runs_left = cur.runs_left - ptt_pkg::RUNS_W'(1);
						if (cur.runs_left == ptt_pkg::RUNS_W'(1)) begin
							upd.nxt.enabled = 1'b0;
						end
					end
				end
			end
			ptt_pkg::CMD_START: begin
				upd.we             = 1'b1;
				upd.nxt.enabled    = 1'b1;
				upd.nxt.runs_left  = run_count;
				upd.nxt.period     = period;
				upd.nxt.countdown  = {1'b0, period};
				upd.nxt.has_action = has_action;
			end
			ptt_pkg::CMD_STOP: begin
				upd.we          = 1'b1;
				upd.nxt.enabled = 1'b0;
			end
			ptt_pkg::CMD_RESUME: begin
				upd.we          = 1'b1;
				upd.nxt.enabled = 1'b1;
			end
			// zero period falls back to the default
			ptt_pkg::CMD_SET_PER: begin
				upd.we         = 1'b1;
				upd.nxt.period = (period == '0) ? ptt_pkg::DEFAULT_PERIOD : period;
			end
			default: begin
				upd.we = 1'b0;
			end
		endcase
	end

endmodule

// ----- hdl/periodic_task_timer_table.sv -----
// Periodic task timer table: NUM_SLOTS timer slots kept in a table with
// one read and one write port and registered read, updated by one shared
// slot unit under a small sequencer. One item is taken at a time; cmd_ready
// is high only while the sequencer is idle. Tick and dispatch walk the slots
// in ascending order, each slot read, then updated and written back;
// dispatch stops early after eight serviced slots. Start, stop, resume and
// set period touch one slot, and a slot index beyond the table touches none.
// The sequencer waits while the result channel stalls. Dispatch gives one
// result per serviced slot, or one idle result; every other command gives
// one result. The table reads as cleared after reset with no clearing pass.
// ----------------------------------------------------------------------------
// periodic_task_timer_table
// command-driven table of periodic timer slots
// ----------------------------------------------------------------------------
module periodic_task_timer_table #(
	parameter int NUM_SLOTS = ptt_pkg::NUM_SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	output logic                              cmd_ready,
	input  logic [ptt_pkg::CMD_W-1:0]         command,
	input  logic [ptt_pkg::SLOT_W-1:0]        slot,
	input  logic signed [ptt_pkg::RUNS_W-1:0] run_count,
	input  logic [ptt_pkg::PERIOD_W-1:0]      period,
	input  logic                              has_action,
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic [ptt_pkg::SLOT_W-1:0]        slot_index,
	output logic                              serviced,
	output logic                              action_fired,
	output logic                              busy_res,
	output logic                              last
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W = $clog2(ptt_pkg::MAX_RESULTS + 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_READ  = 4'b0010,
		ST_EXEC  = 4'b0100,
		ST_FLUSH = 4'b1000
	} state_t;

	state_t                              state_q;
	ptt_pkg::cmd_t                       cmd_q;
	logic [ptt_pkg::SLOT_W-1:0]          slot_q;
	logic signed [ptt_pkg::RUNS_W-1:0]   rc_q;
	logic [ptt_pkg::PERIOD_W-1:0]        per_q;
	logic                                act_q;
	logic [IDX_W-1:0]                    idx_q;
	logic [CNT_W-1:0]                    cnt_q;

	// held result: last one found, emitted when the next shows up or at the end
	logic [ptt_pkg::SLOT_W-1:0]          res_slot_q;
	logic                                res_serv_q;
	logic                                res_act_q;
	logic                                res_busy_q;
	logic                                res_ok_q;

	logic                                res_valid_q;
	logic [ptt_pkg::SLOT_W-1:0]          out_slot_q;
	logic                                out_serv_q;
	logic                                out_act_q;
	logic                                out_busy_q;
	logic                                out_last_q;

	logic                                accept;
	logic                                out_free;
	logic                                go;
	logic                                at_last_idx;
	logic [ptt_pkg::CMP_W-1:0]           slot_ext;
	logic [ptt_pkg::CMP_W-1:0]           idx_ext;
	logic                                slot_in_range;
	logic [CNT_W-1:0]                    cnt_inc;
	logic                                scan_done;

	logic                                out_load;
	logic [ptt_pkg::SLOT_W-1:0]          out_slot_d;
	logic                                out_serv_d;
	logic                                out_act_d;
	logic                                out_busy_d;
	logic                                out_last_d;

	ptt_pkg::slot_entry_t                rd_data;
	ptt_pkg::slot_upd_t                  upd;

	assign accept        = cmd_valid && cmd_ready;
	assign cmd_ready     = (state_q == ST_IDLE);
	assign out_free      = !res_valid_q || res_ready;
	assign go            = (state_q == ST_EXEC) && out_free;
	assign at_last_idx   = (idx_q == IDX_W'(NUM_SLOTS - 1));
	assign slot_ext      = ptt_pkg::CMP_W'(slot);
	assign idx_ext       = ptt_pkg::CMP_W'(idx_q);
	assign slot_in_range = (slot_ext < ptt_pkg::CMP_W'(NUM_SLOTS));
	assign cnt_inc       = cnt_q + CNT_W'(1);
	assign scan_done     = at_last_idx ||
		(upd.serviced && (cnt_inc == CNT_W'(ptt_pkg::MAX_RESULTS)));

	// slot table
	ptt_slot_mem #(
		.DEPTH (NUM_SLOTS),
		.IDX_W (IDX_W)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (state_q == ST_READ),
		.rd_addr (idx_q),
		.rd_data (rd_data),
		.wr_en   (go && upd.we),
		.wr_addr (idx_q),
		.wr_data (upd.nxt)
	);

	// shared update unit
	ptt_slot_alu u_alu (
		.cmd        (cmd_q),
		.cur        (rd_data),
		.run_count  (rc_q),
		.period     (per_q),
		.has_action (act_q),
		.upd        (upd)
	);

	// result register load: an earlier dispatch result, or the final one
	always_comb begin
		out_load   = 1'b0;
		out_slot_d = res_slot_q;
		out_serv_d = res_serv_q;
		out_act_d  = res_act_q;
		out_busy_d = res_busy_q;
		out_last_d = 1'b1;
		if (go && (cmd_q == ptt_pkg::CMD_DISPATCH) && upd.serviced && res_ok_q) begin
			out_load   = 1'b1;
			out_last_d = 1'b0;
		end else if ((state_q == ST_FLUSH) && out_free) begin
			out_load = 1'b1;
			if (!res_ok_q) begin
				out_slot_d = '0;
				out_serv_d = 1'b0;
				out_act_d  = 1'b0;
				out_busy_d = 1'b0;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			cnt_q    <= '0;
			res_ok_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q    <= '0;
						res_ok_q <= (ptt_pkg::cmd_t'(command) != ptt_pkg::CMD_DISPATCH);
						if ((ptt_pkg::cmd_t'(command) == ptt_pkg::CMD_TICK) ||
							(ptt_pkg::cmd_t'(command) == ptt_pkg::CMD_DISPATCH)) begin
							idx_q   <= '0;
							state_q <= ST_READ;
						end else if (slot_in_range) begin
							idx_q   <= slot_ext[IDX_W-1:0];
							state_q <= ST_READ;
						end else begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (go) begin
						case (cmd_q)
							ptt_pkg::CMD_TICK: begin
								if (at_last_idx) begin
									state_q <= ST_FLUSH;
								end else begin
									idx_q   <= idx_q + IDX_W'(1);
									state_q <= ST_READ;
								end
							end
							ptt_pkg::CMD_DISPATCH: begin
								if (upd.serviced) begin
									cnt_q    <= cnt_inc;
									res_ok_q <= 1'b1;
								end
								if (scan_done) begin
									state_q <= ST_FLUSH;
								end else begin
									idx_q   <= idx_q + IDX_W'(1);
									state_q <= ST_READ;
								end
							end
							default: begin
								state_q <= ST_FLUSH;
							end
						endcase
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item fields and held result
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= ptt_pkg::cmd_t'(command);
			slot_q     <= slot;
			rc_q       <= run_count;
			per_q      <= period;
			act_q      <= has_action;
			res_slot_q <= slot;
			res_serv_q <= 1'b0;
			res_act_q  <= 1'b0;
			res_busy_q <= 1'b0;
		end else if (go) begin
			case (cmd_q)
				ptt_pkg::CMD_TICK: begin
					if (idx_ext == ptt_pkg::CMP_W'(slot_q)) begin
						res_busy_q <= rd_data.enabled;
					end
				end
				ptt_pkg::CMD_DISPATCH: begin
					if (upd.serviced) begin
						res_slot_q <= idx_ext[ptt_pkg::SLOT_W-1:0];
						res_serv_q <= 1'b1;
						res_act_q  <= upd.fired;
						res_busy_q <= upd.nxt.enabled;
					end
				end
				default: begin
					res_busy_q <= upd.nxt.enabled;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_slot_q <= out_slot_d;
			out_serv_q <= out_serv_d;
			out_act_q  <= out_act_d;
			out_busy_q <= out_busy_d;
			out_last_q <= out_last_d;
		end
	end

	assign res_valid    = res_valid_q;
	assign slot_index   = out_slot_q;
	assign serviced     = out_serv_q;
	assign action_fired = out_act_q;
	assign busy_res     = out_busy_q;
	assign last         = out_last_q;

endmodule

// ----- hdl/ptt_checker.sv -----
// ----------------------------------------------------------------------------
// ptt_checker
// port-level checks of the periodic task timer table
// ----------------------------------------------------------------------------
`include "periodic_task_timer_table_defines.svh"

module ptt_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cmd_valid,
	input logic                       cmd_ready,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic [ptt_pkg::SLOT_W-1:0] slot_index,
	input logic                       serviced,
	input logic                       action_fired,
	input logic                       last
);

	// a stalled result holds
	`PTT_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(slot_index) && $stable(last), "result changed while stalled")

	// only one item in work at a time
	`PTT_ASSERT_NEXT(a_one_item, cmd_valid && cmd_ready, !cmd_ready, "item taken while busy")

	// an action only fires on a serviced slot
	`PTT_ASSERT_NOW(a_act_serv, res_valid && action_fired, serviced, "action without service")

	// anything but a dispatch service ends its item
	`PTT_ASSERT_NOW(a_plain_last, res_valid && !serviced, last, "non-service result not last")

endmodule

bind periodic_task_timer_table ptt_checker u_ptt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_valid    (cmd_valid),
	.cmd_ready    (cmd_ready),
	.res_valid    (res_valid),
	.res_ready    (res_ready),
	.slot_index   (slot_index),
	.serviced     (serviced),
	.action_fired (action_fired),
	.last         (last)
);

// ----- bench/timer_table_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timer_table_checker
// watches both channels of the timer table, keeps its own copy of the slot
// table, predicts the results of every accepted command item and compares
// every accepted result item field by field, oldest prediction first
// ----------------------------------------------------------------------------
module timer_table_checker
	import ptt_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	input  logic                      cmd_ready,
	input  logic [CMD_W-1:0]          command,
	input  logic [SLOT_W-1:0]         slot,
	input  logic signed [RUNS_W-1:0]  run_count,
	input  logic [PERIOD_W-1:0]       period,
	input  logic                      has_action,
	input  logic                      res_valid,
	input  logic                      res_ready,
	input  logic [SLOT_W-1:0]         slot_index,
	input  logic                      serviced,
	input  logic                      action_fired,
	input  logic                      busy_res,
	input  logic                      last,
	output int                        mismatches,
	output int                        backlog,
	output int                        dispatch_reports,
	output int                        fired_reports
);

	localparam int REPORT_LIMIT = 30;

	// one predicted result item
	typedef struct packed {
		logic [SLOT_W-1:0] slot_index;
		logic              serviced;
		logic              action_fired;
		logic              busy;
		logic              last;
	} timer_report_t;

	// predicted slot table
	logic                     slot_on        [NUM_SLOTS];
	logic signed [RUNS_W-1:0] runs_left      [NUM_SLOTS];
	logic [PERIOD_W-1:0]      reload         [NUM_SLOTS];
	logic signed [CD_W-1:0]   countdown      [NUM_SLOTS];
	logic                     reports_action [NUM_SLOTS];

	timer_report_t pending_reports[$];

	// apply one command to the table and queue the results it causes
	task automatic apply_command(input logic [CMD_W-1:0] c, input logic [SLOT_W-1:0] s,
			input logic signed [RUNS_W-1:0] rc, input logic [PERIOD_W-1:0] p,
			input logic a);
		int i;
		int n;
		logic in_range;
		logic fired;
		logic busy;
		n = 0;
		in_range = (int'(s) < NUM_SLOTS);
		case (c)
			CMD_TICK: begin
				for (i = 0; i < NUM_SLOTS; i++)
					if (countdown[i] > 16'sd0)
						countdown[i] = countdown[i] - 16'sd1;
			end
			CMD_DISPATCH: begin
				for (i = 0; i < NUM_SLOTS && n < MAX_RESULTS; i++) begin
					if (slot_on[i] && countdown[i] == '0) begin
						fired = 1'b0;
						countdown[i] = CD_SPENT;
						// a slot with runs left reloads and may report its action
						if (runs_left[i] != '0) begin
							countdown[i] = {1'b0, reload[i]};
							fired = reports_action[i];
						end
						// finite run counts drop; the slot switches off at zero
						if (runs_left[i] > 16'sd0) begin
							runs_left[i] = runs_left[i] - 16'sd1;
							if (runs_left[i] == '0)
								slot_on[i] = 1'b0;
						end
						pending_reports.push_back({SLOT_W'(i), 1'b1, fired, slot_on[i], 1'b0});
						n++;
					end
				end
			end
			CMD_START: begin
				if (in_range) begin
					slot_on[s] = 1'b1;
					runs_left[s] = rc;
					reload[s] = p;
					countdown[s] = {1'b0, p};
					reports_action[s] = a;
				end
			end
			CMD_STOP: begin
				if (in_range)
					slot_on[s] = 1'b0;
			end
			CMD_RESUME: begin
				if (in_range)
					slot_on[s] = 1'b1;
			end
			CMD_SET_PER: begin
				// zero period falls back to the default, countdown untouched
				if (in_range)
					reload[s] = (p == '0) ? DEFAULT_PERIOD : p;
			end
			default: ;
		endcase

		// close the dispatch burst, or give the single result
		if (c == CMD_DISPATCH && n > 0) begin
			pending_reports[pending_reports.size() - 1].last = 1'b1;
		end else if (c == CMD_DISPATCH) begin
			pending_reports.push_back({SLOT_W'(0), 1'b0, 1'b0, 1'b0, 1'b1});
		end else begin
			busy = in_range ? slot_on[s] : 1'b0;
			pending_reports.push_back({s, 1'b0, 1'b0, busy, 1'b1});
		end
	endtask

	// flag one field that differs from the prediction
	task automatic compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$error("%s: expected %0d, got %0d", name, want, got);
		end
	endtask

	// check one accepted result item against the oldest prediction
	task automatic check_report();
		timer_report_t want;
		if (pending_reports.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$error("unexpected result item: slot_index %0d serviced %0b last %0b",
					slot_index, serviced, last);
		end else begin
			want = pending_reports.pop_front();
			compare_field("slot_index", 8'(want.slot_index), 8'(slot_index));
			compare_field("serviced", 8'(want.serviced), 8'(serviced));
			compare_field("action_fired", 8'(want.action_fired), 8'(action_fired));
			compare_field("busy_res", 8'(want.busy), 8'(busy_res));
			compare_field("last", 8'(want.last), 8'(last));
			if (want.serviced)
				dispatch_reports++;
			if (want.action_fired)
				fired_reports++;
		end
	endtask

	// sample both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_on[i] = 1'b0;
				runs_left[i] = '0;
				reload[i] = '0;
				countdown[i] = '0;
				reports_action[i] = 1'b0;
			end
			pending_reports.delete();
			mismatches = 0;
			backlog = 0;
			dispatch_reports = 0;
			fired_reports = 0;
		end else begin
			if (cmd_valid && cmd_ready)
				apply_command(command, slot, run_count, period, has_action);
			if (res_valid && res_ready)
				check_report();
			backlog = pending_reports.size();
		end
	end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives command items into the timer table: a directed opening over the
// corner cases, then random command mixes with idle gaps on both channels
// and one long result hold-off; the checker predicts and compares results
// ----------------------------------------------------------------------------
module testbench;
	import ptt_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd6;
	localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd7;

	localparam int RANDOM_ITEMS   = 255;
	localparam int CYCLE_LIMIT    = 800000;
	localparam int SQUEEZE_CYCLES = 400;
	localparam int DRAIN_CYCLES   = 60;

	logic                     clk;
	logic                     arst_n;
	logic                     cmd_valid;
	logic                     cmd_ready;
	logic [CMD_W-1:0]         command;
	logic [SLOT_W-1:0]        slot;
	logic signed [RUNS_W-1:0] run_count;
	logic [PERIOD_W-1:0]      period;
	logic                     has_action;
	logic                     res_valid;
	logic                     res_ready;
	logic [SLOT_W-1:0]        slot_index;
	logic                     serviced;
	logic                     action_fired;
	logic                     busy_res;
	logic                     last;

	int mismatches;
	int backlog;
	int dispatch_reports;
	int fired_reports;
	int items_sent;
	int cycle_count = 0;
	bit steady;
	bit squeeze_req;
	bit squeeze_done;

	periodic_task_timer_table dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.command      (command),
		.slot         (slot),
		.run_count    (run_count),
		.period       (period),
		.has_action   (has_action),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.slot_index   (slot_index),
		.serviced     (serviced),
		.action_fired (action_fired),
		.busy_res     (busy_res),
		.last         (last)
	);

	timer_table_checker table_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd_valid        (cmd_valid),
		.cmd_ready        (cmd_ready),
		.command          (command),
		.slot             (slot),
		.run_count        (run_count),
		.period           (period),
		.has_action       (has_action),
		.res_valid        (res_valid),
		.res_ready        (res_ready),
		.slot_index       (slot_index),
		.serviced         (serviced),
		.action_fired     (action_fired),
		.busy_res         (busy_res),
		.last             (last),
		.mismatches       (mismatches),
		.backlog          (backlog),
		.dispatch_reports (dispatch_reports),
		.fired_reports    (fired_reports)
	);

	// clock
	always #1 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// idle gap length: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 50);
	endfunction

	// offer one command item, hold it until accepted, then maybe idle
	task automatic issue_command(input logic [CMD_W-1:0] c, input logic [SLOT_W-1:0] s,
			input logic signed [RUNS_W-1:0] rc, input logic [PERIOD_W-1:0] p,
			input logic a);
		int gap;
		@(negedge clk);
		cmd_valid <= 1'b1;
		command <= c;
		slot <= s;
		run_count <= rc;
		period <= p;
		has_action <= a;
		do
			@(posedge clk);
		while (!cmd_ready);
		items_sent++;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			cmd_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// random command with small periods and run counts so slots come due often
	task automatic issue_random();
		int r;
		logic [CMD_W-1:0] c;
		logic signed [RUNS_W-1:0] rc;
		logic [PERIOD_W-1:0] p;
		r = $urandom_range(0, 99);
		if (r < 30)
			c = CMD_TICK;
		else if (r < 58)
			c = CMD_DISPATCH;
		else if (r < 76)
			c = CMD_START;
		else if (r < 83)
			c = CMD_STOP;
		else if (r < 90)
			c = CMD_RESUME;
		else if (r < 97)
			c = CMD_SET_PER;
		else if ($urandom_range(0, 1))
			c = CMD_UNUSED_A;
		else
			c = CMD_UNUSED_B;
		if ($urandom_range(0, 4) == 0)
			rc = RUNS_W'($urandom);
		else
			rc = RUNS_W'($urandom_range(0, 7)) - 16'sd3;
		if ($urandom_range(0, 4) == 0)
			p = PERIOD_W'($urandom);
		else
			p = PERIOD_W'($urandom_range(0, 4));
		issue_command(c, SLOT_W'($urandom), rc, p, 1'($urandom));
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (squeeze_req && !squeeze_done) begin
				squeeze_done = 1'b1;
				hold_left = SQUEEZE_CYCLES;
			end
			if (hold_left > 0) begin
				res_ready <= 1'b0;
				hold_left--;
			end else begin
				res_ready <= 1'b1;
				if (!steady && $urandom_range(0, 2) == 0)
					hold_left = pick_gap();
			end
		end
	end

	// stimulus and verdict
	initial begin
		int i;
		clk = 1'b0;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		res_ready = 1'b0;
		command = CMD_TICK;
		slot = '0;
		run_count = '0;
		period = '0;
		has_action = 1'b0;
		steady = 1'b0;
		squeeze_req = 1'b0;
		squeeze_done = 1'b0;
		items_sent = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty table: idle dispatch and a tick
		issue_command(CMD_DISPATCH, 3'd0, 16'sd0, 15'd0, 1'b0);
		issue_command(CMD_TICK, 3'd7, 16'sd0, 15'd0, 1'b0);
		// two runs at period zero: fires twice, then switches off
		issue_command(CMD_START, 3'd0, 16'sd2, 15'd0, 1'b1);
		issue_command(CMD_DISPATCH, 3'd0, 16'sd0, 15'd0, 1'b0);
		issue_command(CMD_DISPATCH, 3'd0, 16'sd0, 15'd0, 1'b0);
		// zero runs: serviced once with no action and left spent
		issue_command(CMD_START, 3'd7, 16'sd0, 15'd0, 1'b1);
		issue_command(CMD_DISPATCH, 3'd0, 16'sd0, 15'd0, 1'b0);
		// endless slot at the longest period, finite slot at the largest count
		issue_command(CMD_START, 3'd3, 16'sh8000, 15'h7fff, 1'b1);
		issue_command(CMD_START, 3'd5, 16'sh7fff, 15'd1, 1'b0);
		issue_command(CMD_TICK, 3'd5, 16'sd0, 15'd0, 1'b0);
		issue_command(CMD_DISPATCH, 3'd0, 16'sd0, 15'd0, 1'b0);
		// zero period on set falls back to the default
		issue_command(CMD_SET_PER, 3'd5, 16'sd0, 15'd0, 1'b0);
		issue_command(CMD_SET_PER, 3'd6, 16'sd0, 15'h7fff, 1'b0);
		issue_command(CMD_STOP, 3'd3, 16'sd0, 15'd0, 1'b0);
		issue_command(CMD_RESUME, 3'd3, 16'sd0, 15'd0, 1'b0);
		// unused codes: one with every run count, period and action bit set, one all zero
		issue_command(CMD_UNUSED_A, 3'd3, 16'shffff, 15'h7fff, 1'b1);
		issue_command(CMD_UNUSED_B, 3'd0, 16'sd0, 15'd0, 1'b0);
		// every slot due at once: a full dispatch burst
		for (i = 0; i < NUM_SLOTS_DEF; i++)
			issue_command(CMD_START, SLOT_W'(i), -16'sd1, 15'd0, 1'(i));
		issue_command(CMD_DISPATCH, 3'd0, 16'sd0, 15'd0, 1'b0);

		// random mix: an opening stretch with no idling, then gaps and the hold-off
		steady = 1'b1;
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 60)
				steady = 1'b0;
			if (i == 120)
				squeeze_req = 1'b1;
			issue_random();
		end
		@(negedge clk);
		cmd_valid <= 1'b0;

		// let the last results drain
		while (backlog != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("run covered %0d command items, %0d dispatch reports, %0d with an action",
			items_sent, dispatch_reports, fired_reports);
		$display("one result hold-off of %0d cycles backed up the command side",
			SQUEEZE_CYCLES);
		if (mismatches == 0 && backlog == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- periodic_task_timer_table.f -----
+incdir+hdl
hdl/ptt_pkg.sv
hdl/ptt_slot_mem.sv
hdl/ptt_slot_alu.sv
hdl/periodic_task_timer_table.sv
hdl/ptt_checker.sv
bench/timer_table_checker.sv
bench/testbench.sv
